### rtl/core/trz_pkg.sv
// Shared types and constants of the triangle rasterizer with depth buffer.
// Depends on nothing; every RTL file of the block imports it.
`default_nettype none

package trz_pkg;

    // Screen geometry.
    localparam int WIDTH  = 256;
    localparam int HEIGHT = 256;
    localparam int NPIX   = WIDTH * HEIGHT;
    localparam int AW     = $clog2(NPIX);
    localparam int XW     = $clog2(WIDTH);
    localparam int YW     = $clog2(HEIGHT);

    // Arithmetic widths: vertex minus pixel, product, edge value, its magnitude,
    // denominator and weighted depth sum.
    localparam int DW   = 17;
    localparam int PW   = 2 * DW;
    localparam int WW   = PW + 1;
    localparam int MW   = PW;
    localparam int DENW = MW + 2;
    localparam int NUMW = MW + 2 + 16;
    localparam int QW   = 16;

    localparam logic [15:0] EMPTY_DEPTH = 16'hFFFF;
    localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;

    // Operation codes.
    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic [15:0]        az;
        logic signed [15:0] bx;
        logic signed [15:0] by_coord;
        logic [15:0]        bz;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [15:0]        cz;
        logic [23:0]        fill_color;
        logic [15:0]        pixel_address;
    } t_cmd;

    typedef struct packed {
        logic [23:0] read_color;
        logic [15:0] read_depth;
        logic [16:0] pixels_written;
    } t_res;

    typedef struct packed {
        logic            start;
        logic [NUMW-1:0] num;
        logic [DENW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

### rtl/core/trz_div.sv
// Restoring divider for the interpolated depth, one quotient bit per cycle.
// Depends on trz_pkg.
`default_nettype none

module trz_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire trz_pkg::t_div_req i_req,
    output trz_pkg::t_div_rsp      o_rsp
);
    import trz_pkg::*;

    localparam int SHW = DENW + QW - 1;

    logic [NUMW-1:0] r_rem;
    logic [SHW-1:0]  r_dsh;
    logic [QW-1:0]   r_quot;
    logic [3:0]      r_cnt;
    logic            r_run;
    logic            r_done;
    logic            w_fit;

    // Quotient is known to stay below 2**QW, so QW steps suffice.
    assign w_fit = r_rem >= NUMW'(r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(QW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_dsh  <= SHW'(i_req.den) << (QW - 1);
            r_quot <= '0;
        end else if (r_run) begin
            if (w_fit) begin
                r_rem <= r_rem - NUMW'(r_dsh);
            end
            r_quot <= {r_quot[QW-2:0], w_fit};
            r_dsh  <= r_dsh >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    busy_start_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_run)
        else $error("divider did not start");
    done_once_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held");
    done_ends_run_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_run)
        else $error("divider done while running");

endmodule

`default_nettype wire

### rtl/core/triangle_raster_zbuffer_unit.sv
// Top level of the edge-function triangle rasterizer with depth and color stores.
// Depends on trz_pkg and trz_div.
`default_nettype none

// Command in on start/busy, one result per command on o_valid, shown for
// exactly one cycle; the receiver cannot stall it, so take it when it comes.
// Commands are handled one at a time. A clear sweeps both stores one pixel
// per cycle, then finishes and shows its result. A read addresses the stores,
// registers the data and shows the result. A draw sets up the box, then for
// every pixel of the clipped bounding box forms an edge value per vertex pair and
// does the inside test; a covered pixel adds the weighted depth sum, the
// divider and a read-modify-write; it ends with finish and result. Per-pixel
// cost is set by the bit-serial depth sum and the one-bit-per-cycle divider.
// Stores are undefined until the first clear; draw and read only after one.
module triangle_raster_zbuffer_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire trz_pkg::t_cmd i_cmd,
    output logic               busy,
    output logic               o_valid,
    output trz_pkg::t_res      o_result
);
    import trz_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SETUP = 4'd1;
    localparam logic [3:0] ST_EDGE  = 4'd2;
    localparam logic [3:0] ST_TEST  = 4'd3;
    localparam logic [3:0] ST_MAC   = 4'd4;
    localparam logic [3:0] ST_DIVGO = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_WB    = 4'd7;
    localparam logic [3:0] ST_CLEAR = 4'd8;
    localparam logic [3:0] ST_RD1   = 4'd9;
    localparam logic [3:0] ST_RD2   = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    localparam int BW = 13;   // truncated box coordinate, signed

    // Memories: depth and color, one entry per pixel.
    logic [15:0] depth_mem [NPIX];
    logic [23:0] color_mem [NPIX];

    logic [3:0]  r_state, n_state;
    t_cmd        r_cmd;
    logic [XW-1:0] r_x, r_x0, r_x1;
    logic [YW-1:0] r_y, r_y1;
    logic [AW-1:0] r_row;
    logic [AW-1:0] r_clr;
    logic [1:0]    r_k;
    logic signed [WW-1:0] r_w [3];
    logic [MW-1:0]   r_wm [3];
    logic [DENW-1:0] r_den;
    logic [NUMW-1:0] r_acc;
    logic [3:0]      r_bit;
    logic [16:0]     r_count;
    logic [15:0]     r_rd_depth;
    logic [23:0]     r_rd_color;
    logic            r_valid;
    t_res            r_res;

    logic [AW-1:0] w_pix_addr, w_raddr, w_waddr;
    logic          w_we;
    logic [15:0]   w_wdepth;
    logic [23:0]   w_wcolor;
    t_div_req      w_div_req;
    t_div_rsp      w_div_rsp;
    logic          w_accept;

    assign w_accept = start && !busy;
    assign busy     = (r_state != ST_IDLE);

    // Bounding box: truncate toward zero, clip to the screen.
    function automatic logic signed [BW-1:0] trunc16(input logic signed [15:0] v);
        logic signed [16:0] t;
        t = 17'(v) + (v[15] ? 17'sd15 : 17'sd0);
        return BW'(t >>> 4);
    endfunction

    function automatic logic signed [15:0] min3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [15:0] max3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    logic signed [BW-1:0] w_bx0, w_bx1, w_by0, w_by1;
    logic                 w_empty;

    always_comb begin
        w_bx0 = trunc16(min3(r_cmd.ax, r_cmd.bx, r_cmd.cx));
        w_bx1 = trunc16(max3(r_cmd.ax, r_cmd.bx, r_cmd.cx));
        w_by0 = trunc16(min3(r_cmd.ay, r_cmd.by_coord, r_cmd.cy));
        w_by1 = trunc16(max3(r_cmd.ay, r_cmd.by_coord, r_cmd.cy));
        if (w_bx0 < 0) w_bx0 = '0;
        if (w_by0 < 0) w_by0 = '0;
        if (w_bx1 > BW'(WIDTH - 1))  w_bx1 = BW'(WIDTH - 1);
        if (w_by1 > BW'(HEIGHT - 1)) w_by1 = BW'(HEIGHT - 1);
        w_empty = (w_bx0 > w_bx1) || (w_by0 > w_by1);
    end

    // Edge value for the vertex pair picked by r_k, sampled at the pixel corner.
    logic signed [DW-1:0] w_px, w_py;
    logic signed [DW-1:0] w_dax, w_day, w_dbx, w_dby, w_dcx, w_dcy;
    logic signed [DW-1:0] w_ux, w_uy, w_vx, w_vy;
    logic signed [PW-1:0] w_p1, w_p2;
    logic signed [WW-1:0] w_cross;

    always_comb begin
        w_px  = $signed(DW'({r_x, 4'b0000}));
        w_py  = $signed(DW'({r_y, 4'b0000}));
        w_dax = DW'(r_cmd.ax) - w_px;
        w_day = DW'(r_cmd.ay) - w_py;
        w_dbx = DW'(r_cmd.bx) - w_px;
        w_dby = DW'(r_cmd.by_coord) - w_py;
        w_dcx = DW'(r_cmd.cx) - w_px;
        w_dcy = DW'(r_cmd.cy) - w_py;
        case (r_k)
            2'd0: begin
                w_ux = w_dbx; w_uy = w_dby; w_vx = w_dcx; w_vy = w_dcy;
            end
            2'd1: begin
                w_ux = w_dcx; w_uy = w_dcy; w_vx = w_dax; w_vy = w_day;
            end
            default: begin
                w_ux = w_dax; w_uy = w_day; w_vx = w_dbx; w_vy = w_dby;
            end
        endcase
        w_p1    = w_ux * w_vy;
        w_p2    = w_uy * w_vx;
        w_cross = WW'(w_p1) - WW'(w_p2);
    end

    // Inside test: every edge value at least one whole unit, all of one sign.
    logic w_pos, w_neg;
    assign w_pos = (r_w[0] >= WW'(256)) && (r_w[1] >= WW'(256)) && (r_w[2] >= WW'(256));
    assign w_neg = (r_w[0] <= -WW'(256)) && (r_w[1] <= -WW'(256))
                && (r_w[2] <= -WW'(256));

    // Bit-serial weighted depth sum, most significant depth bit first.
    logic [NUMW-1:0] w_acc_next;
    assign w_acc_next = {r_acc[NUMW-2:0], 1'b0}
        + (r_cmd.az[r_bit] ? NUMW'(r_wm[0]) : '0)
        + (r_cmd.bz[r_bit] ? NUMW'(r_wm[1]) : '0)
        + (r_cmd.cz[r_bit] ? NUMW'(r_wm[2]) : '0);

    logic w_last_x, w_last_y;
    assign w_last_x = (r_x == r_x1);
    assign w_last_y = (r_y == r_y1);

    // Memory access.
    assign w_pix_addr = r_row + AW'(r_x);
    assign w_raddr    = (r_state == ST_RD1) ? AW'(r_cmd.pixel_address) : w_pix_addr;
    assign w_waddr    = (r_state == ST_CLEAR) ? r_clr : w_pix_addr;
    assign w_we       = (r_state == ST_CLEAR)
                     || ((r_state == ST_WB) && (w_div_rsp.quot < r_rd_depth));
    assign w_wdepth   = (r_state == ST_CLEAR) ? EMPTY_DEPTH : w_div_rsp.quot;
    assign w_wcolor   = (r_state == ST_CLEAR) ? 24'd0 : r_cmd.fill_color;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            depth_mem[w_waddr] <= w_wdepth;
            color_mem[w_waddr] <= w_wcolor;
        end
        r_rd_depth <= depth_mem[w_raddr];
        r_rd_color <= color_mem[w_raddr];
    end

    assign w_div_req.start = (r_state == ST_DIVGO);
    assign w_div_req.num   = r_acc;
    assign w_div_req.den   = r_den;

    trz_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_cmd.operation)
                        OP_DRAW:  n_state = ST_SETUP;
                        OP_READ:  n_state = ST_RD1;
                        OP_CLEAR: n_state = ST_CLEAR;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_SETUP: n_state = w_empty ? ST_DONE : ST_EDGE;
            ST_EDGE:  n_state = (r_k == 2'd2) ? ST_TEST : ST_EDGE;
            ST_TEST: begin
                if (w_pos || w_neg) n_state = ST_MAC;
                else if (w_last_x && w_last_y) n_state = ST_DONE;
                else n_state = ST_EDGE;
            end
            ST_MAC:   n_state = (r_bit == 4'd0) ? ST_DIVGO : ST_MAC;
            ST_DIVGO: n_state = ST_DIV;
            ST_DIV:   n_state = w_div_rsp.done ? ST_WB : ST_DIV;
            ST_WB:    n_state = (w_last_x && w_last_y) ? ST_DONE : ST_EDGE;
            ST_CLEAR: n_state = (r_clr == AW'(NPIX - 1)) ? ST_DONE : ST_CLEAR;
            ST_RD1:   n_state = ST_RD2;
            ST_RD2:   n_state = ST_IDLE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_RD2) || (r_state == ST_DONE);
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_cmd;
            r_count <= '0;
            r_clr   <= '0;
        end
        unique case (r_state)
            ST_SETUP: begin
                r_x0  <= XW'(w_bx0);
                r_x1  <= XW'(w_bx1);
                r_y1  <= YW'(w_by1);
                r_x   <= XW'(w_bx0);
                r_y   <= YW'(w_by0);
                r_row <= AW'(YW'(w_by0) * WIDTH);
                r_k   <= 2'd0;
            end
            ST_EDGE: begin
                r_w[r_k] <= w_cross;
                r_k      <= r_k + 2'd1;
            end
            ST_TEST: begin
                for (int i = 0; i < 3; i++) begin
                    r_wm[i] <= w_neg ? MW'(-r_w[i]) : MW'(r_w[i]);
                end
                r_den <= w_neg ? DENW'(-(r_w[0] + r_w[1] + r_w[2]))
                               : DENW'(r_w[0] + r_w[1] + r_w[2]);
                r_acc <= '0;
                r_bit <= 4'd15;
                r_k   <= 2'd0;
            end
            ST_MAC: begin
                r_acc <= w_acc_next;
                r_bit <= r_bit - 4'd1;
            end
            ST_WB: begin
                if (w_we && (r_count != COUNT_MAX)) r_count <= r_count + 17'd1;
            end
            ST_CLEAR: r_clr <= r_clr + AW'(1);
            default: ;
        endcase
        // Advance to the next pixel after a miss or a write-back.
        if (((r_state == ST_TEST) && !(w_pos || w_neg)) || (r_state == ST_WB)) begin
            if (w_last_x) begin
                r_x <= r_x0;
                if (!w_last_y) begin
                    r_y   <= r_y + YW'(1);
                    r_row <= r_row + AW'(WIDTH);
                end
            end else begin
                r_x <= r_x + XW'(1);
            end
        end
        // Result register.
        if (r_state == ST_RD2) begin
            r_res.pixels_written <= '0;
            if (32'(r_cmd.pixel_address) < NPIX) begin
                r_res.read_color <= r_rd_color;
                r_res.read_depth <= r_rd_depth;
            end else begin
                r_res.read_color <= '0;
                r_res.read_depth <= EMPTY_DEPTH;
            end
        end else if (r_state == ST_DONE) begin
            r_res.read_color     <= '0;
            r_res.read_depth     <= '0;
            r_res.pixels_written <= (r_cmd.operation == OP_DRAW) ? r_count : '0;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    accept_busy_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("command accepted without going busy");
    valid_idle_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");
    valid_pulse_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result held past one cycle");
    div_done_wait_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider finished outside wait state");
    write_state_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == ST_CLEAR) || (r_state == ST_WB)))
        else $error("store written outside clear or write-back");

endmodule

`default_nettype wire

### tb/sv/triangle_raster_zbuffer_unit_tb.sv
// Self-checking testbench for triangle_raster_zbuffer_unit: draw, read, clear and
// unknown commands, checked against an in-bench rasterizer and depth buffer.
// Depends on trz_pkg and the RTL of the block.
`timescale 1ns / 100ps

module triangle_raster_zbuffer_unit_tb;

    import trz_pkg::*;

    // Operation code that trz_pkg does not define.
    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int NUM_RANDOM = 1430;
    // Sender waits for the block to drain at this transaction count.
    localparam int DRAIN_AT   = 700;
    // Random clear issued once, mid-run.
    localparam int CLEAR_AT   = 400;
    localparam int QUIET_TAIL = 150;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_cmd cmd;
    logic busy;
    logic o_valid;
    t_res result;

    t_cmd cmd_pending_q[$];
    t_res result_expect_q[$];

    // Own copy of the stores.
    bit [15:0] depth_mem[NPIX];
    bit [23:0] color_mem[NPIX];

    int  n_sent, n_checked, n_errors, gap_left;
    int  n_draw, n_read, n_clear, n_unknown;
    longint pix_total;
    bit  stim_done;

    triangle_raster_zbuffer_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (result)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Rasterize one triangle into the model stores; return covered-and-won pixels.
    function automatic bit [16:0] raster_tri(input t_cmd c);
        longint ax, ay, bx, by, cx, cy, az, bz, cz;
        longint x0, x1, y0, y1, px, py, wa, wb, wc, ta, tb, tc, den, num, z;
        bit [16:0] cnt;
        bit pos, neg;
        int idx;
        ax = longint'(c.ax); ay = longint'(c.ay);
        bx = longint'(c.bx); by = longint'(c.by_coord);
        cx = longint'(c.cx); cy = longint'(c.cy);
        az = longint'(c.az); bz = longint'(c.bz); cz = longint'(c.cz);
        cnt = '0;
        x0 = ax < bx ? ax : bx;  x0 = x0 < cx ? x0 : cx;
        x1 = ax > bx ? ax : bx;  x1 = x1 > cx ? x1 : cx;
        y0 = ay < by ? ay : by;  y0 = y0 < cy ? y0 : cy;
        y1 = ay > by ? ay : by;  y1 = y1 > cy ? y1 : cy;
        // Truncate toward zero, then clip to the screen.
        x0 = x0 / 16; x1 = x1 / 16; y0 = y0 / 16; y1 = y1 / 16;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > WIDTH - 1) x1 = WIDTH - 1;
        if (y1 > HEIGHT - 1) y1 = HEIGHT - 1;
        for (longint y = y0; y <= y1; y++) begin
            for (longint x = x0; x <= x1; x++) begin
                px = x * 16; py = y * 16;
                wa = (bx - px) * (cy - py) - (by - py) * (cx - px);
                wb = (cx - px) * (ay - py) - (cy - py) * (ax - px);
                wc = (ax - px) * (by - py) - (ay - py) * (bx - px);
                ta = wa / 256; tb = wb / 256; tc = wc / 256;
                pos = ta > 0 && tb > 0 && tc > 0;
                neg = ta < 0 && tb < 0 && tc < 0;
                if (!pos && !neg) continue;
                if (neg) begin
                    wa = -wa; wb = -wb; wc = -wc;
                end
                den = wa + wb + wc;
                if (den <= 0) continue;
                num = wa * az + wb * bz + wc * cz;
                z = num / den;
                if (z > 65535) z = 65535;
                idx = int'(y) * WIDTH + int'(x);
                if (z < longint'(depth_mem[idx])) begin
                    depth_mem[idx] = z[15:0];
                    color_mem[idx] = c.fill_color;
                    if (cnt != COUNT_MAX) cnt++;
                end
            end
        end
        return cnt;
    endfunction

    // Apply one accepted command to the model and queue the result it should give.
    function automatic void model_command(input t_cmd c);
        t_res r;
        r = '0;
        case (c.operation)
            OP_DRAW: begin
                r.pixels_written = raster_tri(c);
                n_draw++;
                pix_total += longint'(r.pixels_written);
            end
            OP_READ: begin
                r.read_color = color_mem[c.pixel_address];
                r.read_depth = depth_mem[c.pixel_address];
                n_read++;
            end
            OP_CLEAR: begin
                for (int i = 0; i < NPIX; i++) begin
                    depth_mem[i] = EMPTY_DEPTH;
                    color_mem[i] = '0;
                end
                n_clear++;
            end
            default: n_unknown++;
        endcase
        result_expect_q.push_back(r);
    endfunction

    function automatic t_cmd make_tri(input int x0, input int y0, input int x1, input int y1,
                                      input int x2, input int y2, input int z0, input int z1,
                                      input int z2, input int col);
        t_cmd c;
        c = '0;
        c.operation = OP_DRAW;
        c.ax = 16'(x0); c.ay = 16'(y0); c.az = 16'(z0);
        c.bx = 16'(x1); c.by_coord = 16'(y1); c.bz = 16'(z1);
        c.cx = 16'(x2); c.cy = 16'(y2); c.cz = 16'(z2);
        c.fill_color = 24'(col);
        c.pixel_address = 16'($urandom);
        return c;
    endfunction

    function automatic t_cmd make_read(input int addr);
        t_cmd c;
        logic [255:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        c = raw[$bits(t_cmd)-1:0];
        c.operation = OP_READ;
        c.pixel_address = 16'(addr);
        return c;
    endfunction

    // Small random triangle: mostly near the origin so reads find it, sometimes
    // anywhere in the full coordinate range (mostly off-screen and cheap).
    function automatic t_cmd rand_tri();
        int bx0, by0;
        if ($urandom_range(0, 9) < 7) begin
            bx0 = $urandom_range(0, 511);
            by0 = $urandom_range(0, 511);
        end else begin
            bx0 = $signed(16'($urandom));
            by0 = $signed(16'($urandom));
        end
        // 16-bit wrap of offsets is fine: the model sees the same truncated fields.
        return make_tri(bx0, by0,
                        bx0 + $signed(8'($urandom)) / 2, by0 + $signed(8'($urandom)) / 2,
                        bx0 + $signed(8'($urandom)) / 2, by0 + $signed(8'($urandom)) / 2,
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 24'hFFFFFF));
    endfunction

    // Fill the queue of commands: directed first, then random.
    initial begin
        t_cmd c;
        int   r;
        stim_done = 1'b0;
        // The stores are undefined until the first clear.
        c = '0; c.operation = OP_CLEAR;
        cmd_pending_q.push_back(c);
        cmd_pending_q.push_back(make_read(0));
        cmd_pending_q.push_back(make_read(16'hFFFF));
        // Counter-clockwise triangle, then clockwise over it nearer, then farther.
        cmd_pending_q.push_back(make_tri(16, 16, 160, 24, 40, 150, 4000, 5000, 6000, 24'h123456));
        cmd_pending_q.push_back(make_tri(16, 16, 40, 150, 160, 24, 100, 200, 300, 24'hFFFFFF));
        cmd_pending_q.push_back(make_tri(16, 16, 160, 24, 40, 150, 9000, 9000, 9000, 24'h0000AA));
        cmd_pending_q.push_back(make_read(3 * WIDTH + 3));
        cmd_pending_q.push_back(make_read(5 * WIDTH + 4));
        // Depth extremes.
        cmd_pending_q.push_back(make_tri(200, 200, 330, 210, 220, 320, 0, 0, 0, 24'h000001));
        cmd_pending_q.push_back(make_tri(400, 16, 520, 20, 420, 140, 65535, 65535, 65535,
                                         24'hABCDEF));
        cmd_pending_q.push_back(make_read(14 * WIDTH + 14));
        // Degenerate: collinear vertices.
        cmd_pending_q.push_back(make_tri(0, 0, 80, 80, 160, 160, 10, 10, 10, 24'h00FF00));
        // Off-screen at both coordinate extremes.
        cmd_pending_q.push_back(make_tri(-32768, -32768, -32700, -32768, -32768, -32700,
                                         1, 2, 3, 24'hFF0000));
        cmd_pending_q.push_back(make_tri(32767, 32767, 32700, 32767, 32767, 32700,
                                         1, 2, 3, 24'hFF0000));
        // Straddling the top-left corner: clipping.
        cmd_pending_q.push_back(make_tri(-60, -60, 90, -30, -20, 100, 500, 700, 900, 24'h00FFFF));
        // Straddling the bottom-right corner.
        cmd_pending_q.push_back(make_tri(4000, 4040, 4140, 4070, 4060, 4140, 50, 60, 70,
                                         24'h7F7F7F));
        // Medium-sized triangle.
        cmd_pending_q.push_back(make_tri(480, 480, 1500, 520, 600, 1490, 30, 40000, 20000,
                                         24'h5A5A5A));
        cmd_pending_q.push_back(make_read(50 * WIDTH + 50));
        cmd_pending_q.push_back(make_read(255 * WIDTH + 255));
        c = make_read(0); c.operation = OP_UNKNOWN;
        cmd_pending_q.push_back(c);
        cmd_pending_q.push_back(make_read(0));

        for (int i = 0; i < NUM_RANDOM; i++) begin
            r = $urandom_range(0, 99);
            if (i == CLEAR_AT) begin
                c = '0; c.operation = OP_CLEAR; c.pixel_address = 16'($urandom);
            end else if (r < 50) begin
                c = rand_tri();
            end else if (r < 97) begin
                if ($urandom_range(0, 9) < 7)
                    c = make_read($urandom_range(0, 35) * WIDTH + $urandom_range(0, 35));
                else
                    c = make_read($urandom_range(0, 65535));
            end else begin
                c = make_read($urandom); c.operation = OP_UNKNOWN;
            end
            cmd_pending_q.push_back(c);
        end
        stim_done = 1'b1;
    end

    // Driver: present the head of the queue; advance on each accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            cmd      <= '0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                model_command(cmd);
                n_sent++;
            end
            if (start && busy) begin
                // Hold the command until the block takes it.
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (n_sent == DRAIN_AT && result_expect_q.size() != 0) begin
                start <= 1'b0;
            end else if (cmd_pending_q.size() == 0) begin
                start <= 1'b0;
            end else if (cmd_pending_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                gap_left <= $urandom_range(0, 15);
                start    <= 1'b0;
            end else begin
                cmd   <= cmd_pending_q.pop_front();
                start <= 1'b1;
            end
        end
    end

    // Monitor: take every strobed result and check it against the oldest expectation.
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && o_valid) begin
            if (result_expect_q.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, result);
                n_errors++;
            end else begin
                exp_r = result_expect_q.pop_front();
                n_checked++;
                if (result.read_color !== exp_r.read_color) begin
                    $display("%0t: read_color expected %h actual %h", $time,
                             exp_r.read_color, result.read_color);
                    n_errors++;
                end
                if (result.read_depth !== exp_r.read_depth) begin
                    $display("%0t: read_depth expected %h actual %h", $time,
                             exp_r.read_depth, result.read_depth);
                    n_errors++;
                end
                if (result.pixels_written !== exp_r.pixels_written) begin
                    $display("%0t: pixels_written expected %0d actual %0d", $time,
                             exp_r.pixels_written, result.pixels_written);
                    n_errors++;
                end
            end
        end
    end

    // Reset, then wait for the run to drain.
    initial begin
        n_sent = 0; n_checked = 0; n_errors = 0;
        n_draw = 0; n_read = 0; n_clear = 0; n_unknown = 0; pix_total = 0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        while (cmd_pending_q.size() != 0 || start || result_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d draws (%0d pixels won), %0d reads, %0d clears, %0d unknown ops;",
                 n_draw, pix_total, n_read, n_clear, n_unknown);
        $display("%0d results checked, %0d field errors.", n_checked, n_errors);
        if (n_errors == 0 && result_expect_q.size() == 0)
            $display("triangle_raster_zbuffer_unit: match");
        else
            $display("triangle_raster_zbuffer_unit: mismatch");
        $finish;
    end

    // Watchdog.
    initial begin
        #(64'd200_000_000);
        $display("triangle_raster_zbuffer_unit: mismatch");
        $finish;
    end

endmodule

### triangle_raster_zbuffer_unit.f
rtl/core/trz_pkg.sv
rtl/core/trz_div.sv
rtl/core/triangle_raster_zbuffer_unit.sv
tb/sv/triangle_raster_zbuffer_unit_tb.sv
